FILE: design/header_line_splitter_unit_macros.svh
// ----------------------------------------------------------------------------
// header_line_splitter_unit_macros
// assertion macros used by the checker file of the header line splitter
// ----------------------------------------------------------------------------
`ifndef HEADER_LINE_SPLITTER_UNIT_MACROS_SVH
`define HEADER_LINE_SPLITTER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HLSU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define HLSU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hlsu_pkg.sv
// ----------------------------------------------------------------------------
// hlsu_pkg
// shared constants and types of the header line splitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hlsu_pkg;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    // pending line ending codes
    localparam logic [2:0] PEND_NONE   = 3'd0;
    localparam logic [2:0] PEND_CR     = 3'd1;
    localparam logic [2:0] PEND_LF     = 3'd2;
    localparam logic [2:0] PEND_CRLF   = 3'd3;
    localparam logic [2:0] PEND_CRLFCR = 3'd4;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOL  = 2'd1;
    localparam logic [1:0] KIND_EOH  = 2'd2;

    localparam logic [15:0] LINE_LIMIT_RESET   = 16'd4095;
    localparam logic [15:0] LINE_COUNT_MAX     = 16'hFFFF;
    localparam int          FIFO_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } hlsu_result_t;

    // one classified byte: one or two results
    typedef struct packed {
        logic         pair;
        hlsu_result_t res0;
        hlsu_result_t res1;
    } hlsu_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hlsu_q_status_t;

endpackage

`default_nettype wire

FILE: design/header_line_splitter_unit.sv
// a byte's results pass through the command queue, then leave from the output register
// throughput: one byte per cycle while the queue is not full; results leave at one beat per
// cycle while m_ready is high; a byte that yields two results holds the output side for both
// beats, the command queue (FIFO_DEPTH entries) lets the input side keep going meanwhile
// reset (aresetn low, synchronous): no ending pending, line count zero, line limit 4095, queue empty
// ----------------------------------------------------------------------------
// header_line_splitter_unit
// splits a header byte stream into line characters, end-of-line and end-of-headers marks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module header_line_splitter_unit #(
    parameter int FIFO_DEPTH = hlsu_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_char_out,
    output logic             m_last
);
    import hlsu_pkg::*;

    logic           push;
    logic           pop;
    hlsu_cmd_t      push_cmd;
    hlsu_cmd_t      head_cmd;
    hlsu_q_status_t q_status;

    hlsu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    hlsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    hlsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_char_out (m_char_out),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

FILE: design/hlsu_front.sv
// ----------------------------------------------------------------------------
// hlsu_front
// accepts header bytes, tracks the pending line ending and line length,
// and turns each byte into a command of up to two results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hlsu_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [15:0]             cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_in_byte,
    input  wire hlsu_pkg::hlsu_q_status_t q_status,
    output logic                         push,
    output hlsu_pkg::hlsu_cmd_t          push_cmd
);
    import hlsu_pkg::*;

    logic [2:0]   pend_reg, pend_next;
    logic [15:0]  cnt_reg, cnt_next;
    logic [15:0]  limit_reg;
    logic         accept;
    logic         is_cr, is_lf, is_ws;
    logic         do_eol, do_eoh;
    logic [1:0]   nch;
    logic [15:0]  base, c1, c2;
    logic         emit_a, emit_b;
    logic         v0, v1;
    hlsu_result_t r0, r1;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    assign is_cr = (s_in_byte == BYTE_CR);
    assign is_lf = (s_in_byte == BYTE_LF);
    assign is_ws = (s_in_byte == BYTE_SP) || (s_in_byte == BYTE_TAB);

    always_comb begin
        pend_next = PEND_NONE;
        do_eol    = 1'b0;
        do_eoh    = 1'b0;
        nch       = 2'd0;
        unique case (pend_reg)
            PEND_CR: begin
                if (is_ws) begin
                    nch = 2'd2;
                end else if (is_cr) begin
                    do_eol = 1'b1;
                    do_eoh = 1'b1;
                end else if (is_lf) begin
                    pend_next = PEND_CRLF;
                end else begin
                    do_eol = 1'b1;
                    nch    = 2'd1;
                end
            end
            PEND_LF: begin
                if (is_ws) begin
                    nch = 2'd2;
                end else if (is_lf) begin
                    do_eol = 1'b1;
                    do_eoh = 1'b1;
                end else if (is_cr) begin
                    do_eol    = 1'b1;
                    pend_next = PEND_CR;
                end else begin
                    do_eol = 1'b1;
                    nch    = 2'd1;
                end
            end
            PEND_CRLF: begin
                if (is_ws) begin
                    nch = 2'd2;
                end else if (is_cr) begin
                    pend_next = PEND_CRLFCR;
                end else if (is_lf) begin
                    do_eol = 1'b1;
                    do_eoh = 1'b1;
                end else begin
                    do_eol = 1'b1;
                    nch    = 2'd1;
                end
            end
            PEND_CRLFCR: begin
                // the extra cr is dropped unless the headers end here
                do_eol = 1'b1;
                if (is_cr || is_lf) begin
                    do_eoh = 1'b1;
                end else begin
                    nch = 2'd1;
                end
            end
            default: begin
                // nothing pending, unused codes behave the same
                if (is_cr) begin
                    pend_next = PEND_CR;
                end else if (is_lf) begin
                    pend_next = PEND_LF;
                end else begin
                    nch = 2'd1;
                end
            end
        endcase
    end

    // line length: count restarts on end of line, saturates at the top
    always_comb begin
        base   = do_eol ? 16'd0 : cnt_reg;
        emit_a = (base < limit_reg);
        c1     = (base == LINE_COUNT_MAX) ? base : base + 16'd1;
        emit_b = (c1 < limit_reg);
        c2     = (c1 == LINE_COUNT_MAX) ? c1 : c1 + 16'd1;
        if (do_eoh) begin
            cnt_next = 16'd0;
        end else if (nch == 2'd2) begin
            cnt_next = c2;
        end else if (nch == 2'd1) begin
            cnt_next = c1;
        end else begin
            cnt_next = base;
        end
    end

    always_comb begin
        r1.kind = KIND_CHAR;
        r1.ch   = s_in_byte;
        if (do_eoh) begin
            v0      = 1'b1;
            r0.kind = KIND_EOL;
            r0.ch   = 8'd0;
            v1      = 1'b1;
            r1.kind = KIND_EOH;
            r1.ch   = 8'd0;
        end else if (do_eol) begin
            v0      = 1'b1;
            r0.kind = KIND_EOL;
            r0.ch   = 8'd0;
            v1      = (nch == 2'd1) && emit_a;
        end else begin
            // folded ending gives a space ahead of the byte itself
            v0      = (nch != 2'd0) && emit_a;
            r0.kind = KIND_CHAR;
            r0.ch   = (nch == 2'd2) ? BYTE_SP : s_in_byte;
            v1      = (nch == 2'd2) && emit_b;
        end
        push_cmd.pair = v0 && v1;
        push_cmd.res0 = v0 ? r0 : r1;
        push_cmd.res1 = r1;
    end

    assign push = accept && (v0 || v1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= PEND_NONE;
            cnt_reg   <= 16'd0;
            limit_reg <= LINE_LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                pend_reg <= pend_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/hlsu_fifo.sv
// ----------------------------------------------------------------------------
// hlsu_fifo
// short command queue between the classifying front and the output side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hlsu_fifo #(
    parameter int DEPTH = hlsu_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     push,
    input  wire hlsu_pkg::hlsu_cmd_t      push_cmd,
    input  wire logic                     pop,
    output hlsu_pkg::hlsu_cmd_t           head_cmd,
    output hlsu_pkg::hlsu_q_status_t      q_status
);
    import hlsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hlsu_cmd_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        nxt = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
        return nxt;
    endfunction

    assign head_cmd       = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/hlsu_back.sv
// ----------------------------------------------------------------------------
// hlsu_back
// unpacks queued commands into result beats through an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hlsu_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire hlsu_pkg::hlsu_cmd_t      head_cmd,
    input  wire hlsu_pkg::hlsu_q_status_t q_status,
    output logic                          pop,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_kind,
    output logic [7:0]                    m_char_out,
    output logic                          m_last
);
    import hlsu_pkg::*;

    logic         valid_reg;
    logic         idx_reg;
    logic [1:0]   kind_reg;
    logic [7:0]   char_reg;
    logic         last_reg;
    logic         load;
    logic         is_last;
    hlsu_result_t sel;

    // output register takes a new beat when empty or being drained
    assign load    = (!valid_reg || m_ready) && !q_status.empty;
    assign sel     = idx_reg ? head_cmd.res1 : head_cmd.res0;
    assign is_last = !head_cmd.pair || idx_reg;
    assign pop     = load && is_last;

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= sel.kind;
            char_reg <= sel.ch;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= !is_last;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = valid_reg;
    assign m_kind     = kind_reg;
    assign m_char_out = char_reg;
    assign m_last     = last_reg;

endmodule

`default_nettype wire

FILE: design/hlsu_checker.sv
// ----------------------------------------------------------------------------
// hlsu_checker
// port-level checks of the header line splitter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "header_line_splitter_unit_macros.svh"

module hlsu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_in_byte,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_kind,
    input wire logic [7:0]  m_char_out,
    input wire logic        m_last
);
    import hlsu_pkg::*;

    // a waiting input beat keeps its byte
    `HLSU_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_in_byte), "input beat changed while waiting")

    // stalled beat keeps its payload
    `HLSU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_char_out) && $stable(m_last), "result beat changed while stalled")

    // marks carry no character
    `HLSU_ASSERT_SAME(a_mark_zero, aclk, aresetn, m_valid && (m_kind != KIND_CHAR), m_char_out == 8'd0, "end mark with non-zero character")

    // end of headers is always the closing beat of its byte
    `HLSU_ASSERT_SAME(a_eoh_last, aclk, aresetn, m_valid && (m_kind == KIND_EOH), m_last, "end of headers not flagged last")

    // the second beat of a byte follows straight after the first
    `HLSU_ASSERT_NEXT(a_pair_follow, aclk, aresetn, m_valid && m_ready && !m_last, m_valid, "gap inside the results of one byte")

endmodule

bind header_line_splitter_unit hlsu_checker u_hlsu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_in_byte   (s_in_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_char_out  (m_char_out),
    .m_last      (m_last)
);

`default_nettype wire
